// ----- rtl/core/c_subset_lexer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// c_subset_lexer_unit_assert.svh
// Assertion macros used by the lexer checker.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_UNIT_ASSERT_SVH
`define C_SUBSET_LEXER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSL_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication, disabled in reset
`define CSL_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// ----- rtl/core/csl_pkg.sv -----
// ----------------------------------------------------------------------------
// csl_pkg
// Types, codes, character classes and keyword tables of the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

    localparam int POS_W   = 24;
    localparam int VAL_W   = 64;
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int NUM_KW  = 6;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // token kinds
    localparam logic [2:0] KIND_PUNCT = 3'd0;
    localparam logic [2:0] KIND_IDENT = 3'd1;
    localparam logic [2:0] KIND_KW    = 3'd2;
    localparam logic [2:0] KIND_NUM   = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;
    localparam logic [2:0] KIND_ERR   = 3'd5;

    // lexer modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUM   = 3'd1;
    localparam logic [2:0] MODE_IDENT = 3'd2;
    localparam logic [2:0] MODE_PUNCT = 3'd3;
    localparam logic [2:0] MODE_DROP  = 3'd4;

    localparam logic [NUM_KW-1:0] KW_ALL = {NUM_KW{1'b1}};

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BTICK = 8'h60;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_USCR  = 8'h5F;

    typedef struct packed {
        logic [2:0]       kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
        logic [VAL_W-1:0] value;
        logic [2:0]       kw;
        logic [7:0]       p1;
        logic [7:0]       p2;
    } token_t;

    // all tokens caused by one input item, packed from slot 0
    typedef struct packed {
        logic [1:0]                count;
        token_t [MAX_RES-1:0]      tok;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_A) && (c <= CH_Z)) ||
               (c == CH_USCR);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return ((c >= CH_BANG) && (c <= CH_SLASH)) || ((c >= CH_COLON) && (c <= CH_AT)) ||
               ((c >= CH_LBRK) && (c <= CH_BTICK)) || ((c >= CH_LBRC) && (c <= CH_TILDE));
    endfunction

    // first byte of a possible two-byte operator
    function automatic logic is_pair_lead(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
    endfunction

    // keyword text, first character in the top byte, zero padded
    function automatic logic [47:0] kw_text(input logic [2:0] i);
        logic [47:0] s;
        s = '0;
        unique case (i)
            3'd0:    s = "return";
            3'd1:    s = {"if", 32'h0};
            3'd2:    s = {"else", 16'h0};
            3'd3:    s = {"for", 24'h0};
            3'd4:    s = {"while", 8'h0};
            3'd5:    s = {"int", 24'h0};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] i);
        logic [2:0] n;
        n = 3'd0;
        unique case (i)
            3'd0:    n = 3'd6;
            3'd1:    n = 3'd2;
            3'd2:    n = 3'd4;
            3'd3:    n = 3'd3;
            3'd4:    n = 3'd5;
            3'd5:    n = 3'd3;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // prefix match: keep keywords whose character at this offset is c
    function automatic logic [NUM_KW-1:0] kw_take(input logic [NUM_KW-1:0] mask,
                                                  input logic [POS_W-1:0] run,
                                                  input logic [7:0] c);
        logic [NUM_KW-1:0] keep;
        logic [47:0]       s;
        keep = '0;
        for (int i = 0; i < NUM_KW; i++) begin
            s = kw_text(3'(i));
            if (mask[i] && (run < POS_W'(kw_len(3'(i)))) &&
                (s[47 - 8 * run[2:0] -: 8] == c)) begin
                keep[i] = 1'b1;
            end
        end
        return keep;
    endfunction

    function automatic logic [POS_W-1:0] run_inc(input logic [POS_W-1:0] r);
        return (r == POS_MAX) ? r : r + POS_W'(1);
    endfunction

    // acc*10 + digit, saturating
    function automatic logic [VAL_W-1:0] acc_next(input logic [VAL_W-1:0] a,
                                                  input logic [7:0] c);
        logic [VAL_W+3:0] p;
        p = ({4'b0, a} << 3) + ({4'b0, a} << 1) + (VAL_W + 4)'(c[3:0]);
        return (|p[VAL_W+3:VAL_W]) ? {VAL_W{1'b1}} : p[VAL_W-1:0];
    endfunction

    function automatic token_t mk_tok(input logic [2:0] kind,
                                      input logic [POS_W-1:0] start,
                                      input logic [POS_W-1:0] length,
                                      input logic [VAL_W-1:0] value,
                                      input logic [2:0] kw,
                                      input logic [7:0] p1,
                                      input logic [7:0] p2);
        token_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.value  = value;
        t.kw     = kw;
        t.p1     = p1;
        t.p2     = p2;
        return t;
    endfunction

    function automatic logic mode_open(input logic [2:0] m);
        return (m == MODE_NUM) || (m == MODE_IDENT) || (m == MODE_PUNCT);
    endfunction

    // token that an open mode yields when closed
    function automatic token_t close_tok(input logic [2:0] m,
                                         input logic [POS_W-1:0] tb,
                                         input logic [POS_W-1:0] run,
                                         input logic [VAL_W-1:0] acc,
                                         input logic [NUM_KW-1:0] mask,
                                         input logic [7:0] pend);
        token_t     t;
        logic [2:0] kind;
        logic [2:0] idx;
        kind = KIND_IDENT;
        idx  = 3'd0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (mask[i] && (run == POS_W'(kw_len(3'(i))))) begin
                kind = KIND_KW;
                idx  = 3'(i);
            end
        end
        priority if (m == MODE_NUM) begin
            t = mk_tok(KIND_NUM, tb, run, acc, 3'd0, 8'd0, 8'd0);
        end else if (m == MODE_IDENT) begin
            t = mk_tok(kind, tb, run, '0, idx, 8'd0, 8'd0);
        end else begin
            t = mk_tok(KIND_PUNCT, tb, POS_W'(1), '0, 3'd0, pend, 8'd0);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/csl_if.sv -----
// ----------------------------------------------------------------------------
// csl_if
// Valid/ready channels of the lexer: text bytes in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface csl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, has_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, has_byte, end_of_text, output ready);
endinterface

interface csl_out_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                token_kind;
    logic [csl_pkg::POS_W-1:0] token_start;
    logic [csl_pkg::POS_W-1:0] token_length;
    logic [csl_pkg::VAL_W-1:0] number_value;
    logic [2:0]                keyword_index;
    logic [7:0]                punct_first;
    logic [7:0]                punct_second;
    logic                      last_of_run;

    modport source (output valid, token_kind, token_start, token_length, number_value,
                    keyword_index, punct_first, punct_second, last_of_run,
                    input ready);
    modport sink   (input valid, token_kind, token_start, token_length, number_value,
                    keyword_index, punct_first, punct_second, last_of_run,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/csl_front.sv -----
// ----------------------------------------------------------------------------
// csl_front
// Takes one text item per cycle while the queue takes pushes, runs the lexer
// state and pushes the tokens the item causes as one bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    csl_in_if.sink                text,
    output logic                  push_valid,
    output csl_pkg::bundle_t      push_data,
    input  wire logic             push_ready
);

    logic [2:0]                        mode_reg,  mode_next;
    logic [csl_pkg::POS_W-1:0]         pos_reg,   pos_next;
    logic [csl_pkg::POS_W-1:0]         begin_reg, begin_next;
    logic [csl_pkg::POS_W-1:0]         run_reg,   run_next;
    logic [csl_pkg::VAL_W-1:0]         acc_reg,   acc_next;
    logic [csl_pkg::NUM_KW-1:0]        mask_reg,  mask_next;
    logic [7:0]                        pend_reg,  pend_next;

    logic                              accept;
    logic [2:0]                        m;
    logic                              done;
    logic [7:0]                        c;
    csl_pkg::token_t                   ta, tb, tc, td;
    logic                              va, vb, vc, vd;
    csl_pkg::token_t [2:0]             cand;
    logic [2:0]                        cv;
    logic [1:0]                        slot;
    csl_pkg::bundle_t                  bund;

    assign text.ready = push_ready;
    assign accept     = text.valid && text.ready;
    assign c          = text.text_byte;

    always_comb
    begin
        // unused mode codes behave as idle
        m          = (mode_reg > csl_pkg::MODE_DROP) ? csl_pkg::MODE_IDLE : mode_reg;
        mode_next  = m;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        run_next   = run_reg;
        acc_next   = acc_reg;
        mask_next  = mask_reg;
        pend_next  = pend_reg;
        done = 1'b0;
        ta = '0; tb = '0; tc = '0; td = '0;
        va = 1'b0; vb = 1'b0; vc = 1'b0; vd = 1'b0;

        if (text.has_byte)
        begin
            if (m != csl_pkg::MODE_DROP)
            begin
                if (m == csl_pkg::MODE_PUNCT)
                begin
                    if (c == csl_pkg::CH_EQ)
                    begin
                        ta = csl_pkg::mk_tok(csl_pkg::KIND_PUNCT, begin_reg,
                                             csl_pkg::POS_W'(2), '0, 3'd0,
                                             pend_reg, csl_pkg::CH_EQ);
                        va        = 1'b1;
                        mode_next = csl_pkg::MODE_IDLE;
                        pend_next = 8'd0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        ta = csl_pkg::close_tok(m, begin_reg, run_reg, acc_reg,
                                                mask_reg, pend_reg);
                        va        = 1'b1;
                        mode_next = csl_pkg::MODE_IDLE;
                        run_next  = '0;
                        acc_next  = '0;
                        mask_next = csl_pkg::KW_ALL;
                        pend_next = 8'd0;
                    end
                end
                if (!done)
                begin
                    if ((mode_next == csl_pkg::MODE_NUM) && csl_pkg::is_digit(c))
                    begin
                        acc_next = csl_pkg::acc_next(acc_next, c);
                        run_next = csl_pkg::run_inc(run_next);
                    end
                    else if ((mode_next == csl_pkg::MODE_IDENT) &&
                             (csl_pkg::is_alpha(c) || csl_pkg::is_digit(c)))
                    begin
                        mask_next = csl_pkg::kw_take(mask_next, run_next, c);
                        run_next  = csl_pkg::run_inc(run_next);
                    end
                    else
                    begin
                        if ((mode_next == csl_pkg::MODE_NUM) ||
                            (mode_next == csl_pkg::MODE_IDENT))
                        begin
                            ta = csl_pkg::close_tok(mode_next, begin_next, run_next,
                                                    acc_next, mask_next, pend_next);
                            va = 1'b1;
                        end
                        mode_next = csl_pkg::MODE_IDLE;
                        run_next  = '0;
                        acc_next  = '0;
                        mask_next = csl_pkg::KW_ALL;
                        pend_next = 8'd0;
                        priority if (csl_pkg::is_space(c))
                        begin
                            mode_next = csl_pkg::MODE_IDLE;
                        end
                        else if (csl_pkg::is_digit(c))
                        begin
                            mode_next  = csl_pkg::MODE_NUM;
                            begin_next = pos_reg;
                            run_next   = csl_pkg::POS_W'(1);
                            acc_next   = csl_pkg::VAL_W'(c[3:0]);
                        end
                        else if (csl_pkg::is_alpha(c))
                        begin
                            mode_next  = csl_pkg::MODE_IDENT;
                            begin_next = pos_reg;
                            mask_next  = csl_pkg::kw_take(csl_pkg::KW_ALL, '0, c);
                            run_next   = csl_pkg::POS_W'(1);
                        end
                        else if (csl_pkg::is_pair_lead(c))
                        begin
                            mode_next  = csl_pkg::MODE_PUNCT;
                            begin_next = pos_reg;
                            pend_next  = c;
                        end
                        else if (csl_pkg::is_punct(c))
                        begin
                            tb = csl_pkg::mk_tok(csl_pkg::KIND_PUNCT, pos_reg,
                                                 csl_pkg::POS_W'(1), '0, 3'd0, c, 8'd0);
                            vb = 1'b1;
                        end
                        else
                        begin
                            tb = csl_pkg::mk_tok(csl_pkg::KIND_ERR, pos_reg,
                                                 csl_pkg::POS_W'(1), '0, 3'd0, 8'd0, 8'd0);
                            vb        = 1'b1;
                            mode_next = csl_pkg::MODE_DROP;
                        end
                    end
                end
            end
            pos_next = pos_reg + csl_pkg::POS_W'(1);
        end

        if (text.end_of_text)
        begin
            if (csl_pkg::mode_open(mode_next))
            begin
                tc = csl_pkg::close_tok(mode_next, begin_next, run_next, acc_next,
                                        mask_next, pend_next);
                vc = 1'b1;
            end
            td = csl_pkg::mk_tok(csl_pkg::KIND_END, pos_next, '0, '0, 3'd0, 8'd0, 8'd0);
            vd = 1'b1;
            mode_next  = csl_pkg::MODE_IDLE;
            pos_next   = '0;
            begin_next = '0;
            run_next   = '0;
            acc_next   = '0;
            mask_next  = csl_pkg::KW_ALL;
            pend_next  = 8'd0;
        end
    end

    // byte's own token and the end-close never both occur
    always_comb
    begin
        cand[0] = ta;
        cand[1] = vb ? tb : tc;
        cand[2] = td;
        cv      = {vd, vb | vc, va};
        bund    = '0;
        slot    = 2'd0;
        for (int i = 0; i < csl_pkg::MAX_RES; i++)
        begin
            if (cv[i])
            begin
                bund.tok[slot] = cand[i];
                slot           = slot + 2'd1;
            end
        end
        bund.count = slot;
    end

    assign push_valid = accept && (|cv);
    assign push_data  = bund;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csl_pkg::MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            run_reg   <= '0;
            acc_reg   <= '0;
            mask_reg  <= csl_pkg::KW_ALL;
            pend_reg  <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            run_reg   <= run_next;
            acc_reg   <= acc_next;
            mask_reg  <= mask_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/csl_queue.sv -----
// ----------------------------------------------------------------------------
// csl_queue
// Small FIFO of token bundles between the lexer front and the token sender.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire csl_pkg::bundle_t push_data,
    output logic                  push_ready,
    output logic                  pop_valid,
    output csl_pkg::bundle_t      pop_data,
    input  wire logic             pop
);

    csl_pkg::bundle_t             mem_reg [csl_pkg::Q_DEPTH];
    logic [csl_pkg::Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [csl_pkg::Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [csl_pkg::Q_AW:0]       cnt_reg,    cnt_next;
    logic                         do_push, do_pop;

    assign push_ready = (cnt_reg != (csl_pkg::Q_AW + 1)'(csl_pkg::Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + csl_pkg::Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + csl_pkg::Q_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + (csl_pkg::Q_AW + 1)'(1);
            2'b01:   cnt_next = cnt_reg - (csl_pkg::Q_AW + 1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/csl_back.sv -----
// ----------------------------------------------------------------------------
// csl_back
// Walks the head bundle one token per cycle into the output register while it is free or read.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire csl_pkg::bundle_t head,
    output logic                  pop,
    csl_out_if.source             tokens
);

    logic                 out_valid_reg, out_valid_next;
    csl_pkg::token_t      out_tok_reg,   out_tok_next;
    logic                 out_last_reg,  out_last_next;
    logic [1:0]           sel_reg,       sel_next;
    logic                 load;
    logic                 is_last;

    assign load    = !out_valid_reg || tokens.ready;
    assign is_last = (sel_reg == (head.count - 2'd1));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_tok_next   = out_tok_reg;
        out_last_next  = out_last_reg;
        sel_next       = sel_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_tok_next  = head.tok[sel_reg];
                out_last_next = is_last;
                pop           = is_last;
                sel_next      = is_last ? 2'd0 : sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
    end

    assign tokens.valid         = out_valid_reg;
    assign tokens.token_kind    = out_tok_reg.kind;
    assign tokens.token_start   = out_tok_reg.start;
    assign tokens.token_length  = out_tok_reg.length;
    assign tokens.number_value  = out_tok_reg.value;
    assign tokens.keyword_index = out_tok_reg.kw;
    assign tokens.punct_first   = out_tok_reg.p1;
    assign tokens.punct_second  = out_tok_reg.p2;
    assign tokens.last_of_run   = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/c_subset_lexer_unit.sv -----
// ----------------------------------------------------------------------------
// c_subset_lexer_unit
// Streaming lexer for a small C subset: text bytes in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one item per source byte (has_byte=1), or a bare end marker
//            (has_byte=0, end_of_text=1); end_of_text closes the text.
//   tokens : numbers, identifiers, keywords, punctuators, error and end
//            tokens; last_of_run flags the final token of one text item.
//   Throughput: one text item per cycle while the token queue has room.
//   Tokens leave one per cycle while tokens.ready is high; an item that causes
//   two or three tokens keeps the sender busy until all have left, absorbed by
//   the 4-entry bundle queue between the lexer front and the token sender.
//   Path: an accepted item is written into the bundle queue; its first token
//   is then loaded into the output register once that register is free, and
//   further tokens follow one per cycle while tokens.ready is high.
//   Reset: lexer idle at offset zero, queue and output register empty.
//   Stall: tokens.valid holds with stable fields until tokens.ready; text
//   keeps flowing until the queue fills, then text.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    csl_in_if.sink      text,
    csl_out_if.source   tokens
);

    logic                 push_valid;
    logic                 push_ready;
    csl_pkg::bundle_t     push_data;
    logic                 head_valid;
    csl_pkg::bundle_t     head;
    logic                 pop;

    csl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    csl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (head_valid),
        .pop_data   (head),
        .pop        (pop)
    );

    csl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tokens     (tokens)
    );

endmodule

`default_nettype wire

// ----- rtl/core/csl_checker.sv -----
// ----------------------------------------------------------------------------
// csl_checker
// Port-level checks on the token channel of the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_subset_lexer_unit_assert.svh"

module csl_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      valid,
    input wire logic                      ready,
    input wire logic [2:0]                token_kind,
    input wire logic [csl_pkg::POS_W-1:0] token_length,
    input wire logic [csl_pkg::VAL_W-1:0] number_value,
    input wire logic [7:0]                punct_first,
    input wire logic [7:0]                punct_second,
    input wire logic                      last_of_run
);

    `CSL_ASSERT_NXT(a_hold, clk, rst_n, valid && !ready, valid && $stable(token_kind) && $stable(token_length))
    `CSL_ASSERT_IMP(a_end, clk, rst_n, valid && (token_kind == csl_pkg::KIND_END), (token_length == '0) && last_of_run)
    `CSL_ASSERT_IMP(a_value, clk, rst_n, valid && (token_kind != csl_pkg::KIND_NUM), number_value == '0)
    `CSL_ASSERT_IMP(a_punct, clk, rst_n, valid && (token_kind != csl_pkg::KIND_PUNCT), (punct_first == 8'd0) && (punct_second == 8'd0))

endmodule

bind c_subset_lexer_unit csl_checker u_csl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (tokens.valid),
    .ready        (tokens.ready),
    .token_kind   (tokens.token_kind),
    .token_length (tokens.token_length),
    .number_value (tokens.number_value),
    .punct_first  (tokens.punct_first),
    .punct_second (tokens.punct_second),
    .last_of_run  (tokens.last_of_run)
);

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C subset lexer. A scoreboard predicts the
// tokens of every accepted text item; results are compared field by field
// as they arrive. Stimulus is a directed prologue, then random texts of
// well-formed tokens with some invalid bytes, garbage and empty items, under
// sender bursts, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int ITEM_TARGET = 340;
    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    localparam logic [csl_pkg::VAL_W-1:0] VAL_TOP = {csl_pkg::VAL_W{1'b1}};

    typedef enum int {KW_RETURN, KW_IF, KW_ELSE, KW_FOR, KW_WHILE, KW_INT} kw_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_MOSTLY} stall_t;

    typedef struct {
        logic [2:0]                kind;
        logic [csl_pkg::POS_W-1:0] start;
        logic [csl_pkg::POS_W-1:0] length;
        logic [csl_pkg::VAL_W-1:0] value;
        logic [2:0]                kw;
        logic [7:0]                p1;
        logic [7:0]                p2;
        logic                      last;
    } lex_token_t;

    class lex_tracker;
        logic [2:0]                 mode;
        logic [csl_pkg::POS_W-1:0]  offset;
        logic [csl_pkg::POS_W-1:0]  tok_begin;
        logic [csl_pkg::POS_W-1:0]  run;
        logic [csl_pkg::VAL_W-1:0]  acc;
        logic [csl_pkg::NUM_KW-1:0] kw_live;
        logic [7:0]                 held;
        lex_token_t                 tokens_due[$];
        int unsigned                mismatches;
        int unsigned                matched;
        int unsigned                saturated;
        int unsigned                kind_seen[8];

        function new();
            clear();
            mismatches = 0;
            matched    = 0;
            saturated  = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        static function string kw_word(kw_t k);
            unique case (k)
                KW_RETURN: return "return";
                KW_IF:     return "if";
                KW_ELSE:   return "else";
                KW_FOR:    return "for";
                KW_WHILE:  return "while";
                KW_INT:    return "int";
                default:   return "";
            endcase
        endfunction

        static function bit char_digit(logic [7:0] c);
            return c >= csl_pkg::CH_0 && c <= csl_pkg::CH_9;
        endfunction

        static function bit char_letter(logic [7:0] c);
            return (c >= csl_pkg::CH_LA && c <= csl_pkg::CH_LZ) ||
                   (c >= csl_pkg::CH_A && c <= csl_pkg::CH_Z) || c == csl_pkg::CH_USCR;
        endfunction

        static function bit char_blank(logic [7:0] c);
            return c == csl_pkg::CH_SPACE || (c >= csl_pkg::CH_TAB && c <= csl_pkg::CH_CR);
        endfunction

        static function bit char_mark(logic [7:0] c);
            return (c >= csl_pkg::CH_BANG && c <= csl_pkg::CH_SLASH) ||
                   (c >= csl_pkg::CH_COLON && c <= csl_pkg::CH_AT) ||
                   (c >= csl_pkg::CH_LBRK && c <= csl_pkg::CH_BTICK) ||
                   (c >= csl_pkg::CH_LBRC && c <= csl_pkg::CH_TILDE);
        endfunction

        function void clear();
            mode      = csl_pkg::MODE_IDLE;
            offset    = '0;
            tok_begin = '0;
            run       = '0;
            acc       = '0;
            kw_live   = csl_pkg::KW_ALL;
            held      = '0;
        endfunction

        function void predict_token(logic [2:0] kind, logic [csl_pkg::POS_W-1:0] start,
                                    logic [csl_pkg::POS_W-1:0] len,
                                    logic [csl_pkg::VAL_W-1:0] value,
                                    logic [2:0] kw, logic [7:0] p1, logic [7:0] p2);
            lex_token_t t;
            t.kind   = kind;
            t.start  = start;
            t.length = len;
            t.value  = value;
            t.kw     = kw;
            t.p1     = p1;
            t.p2     = p2;
            t.last   = 1'b0;
            tokens_due.push_back(t);
        endfunction

        // narrow the set of keywords that still match the identifier so far
        function void ident_char(logic [7:0] c);
            logic [csl_pkg::NUM_KW-1:0] keep;
            string                      w;
            keep = '0;
            for (int k = 0; k < csl_pkg::NUM_KW; k++) begin
                w = kw_word(kw_t'(k));
                if (kw_live[k] && run < w.len() && w[int'(run)] == c)
                    keep[k] = 1'b1;
            end
            kw_live = keep;
            if (run != csl_pkg::POS_MAX)
                run = run + 1'b1;
        endfunction

        function void close_token();
            logic [2:0] kind;
            logic [2:0] idx;
            string      w;
            unique case (mode)
                csl_pkg::MODE_NUM:
                    predict_token(csl_pkg::KIND_NUM, tok_begin, run, acc, 3'd0, 8'd0, 8'd0);
                csl_pkg::MODE_IDENT:
                begin
                    kind = csl_pkg::KIND_IDENT;
                    idx  = 3'd0;
                    for (int k = 0; k < csl_pkg::NUM_KW; k++) begin
                        w = kw_word(kw_t'(k));
                        if (kw_live[k] && run == w.len())
                        begin
                            kind = csl_pkg::KIND_KW;
                            idx  = 3'(k);
                        end
                    end
                    predict_token(kind, tok_begin, run, '0, idx, 8'd0, 8'd0);
                end
                csl_pkg::MODE_PUNCT:
                    predict_token(csl_pkg::KIND_PUNCT, tok_begin, csl_pkg::POS_W'(1), '0,
                                  3'd0, held, 8'd0);
                default:
                    return;
            endcase
            mode    = csl_pkg::MODE_IDLE;
            run     = '0;
            acc     = '0;
            kw_live = csl_pkg::KW_ALL;
            held    = '0;
        endfunction

        function void take_byte(logic [7:0] c, bit has, bit eot);
            int                        first_new;
            logic [csl_pkg::POS_W-1:0] here;
            logic [csl_pkg::VAL_W-1:0] d;
            bit                        paired;
            lex_token_t                t;
            first_new = tokens_due.size();
            if (mode > csl_pkg::MODE_DROP)
                mode = csl_pkg::MODE_IDLE;
            if (has)
            begin
                here   = offset;
                paired = 1'b0;
                if (mode != csl_pkg::MODE_DROP)
                begin
                    if (mode == csl_pkg::MODE_PUNCT)
                    begin
                        if (c == csl_pkg::CH_EQ)
                        begin
                            predict_token(csl_pkg::KIND_PUNCT, tok_begin, csl_pkg::POS_W'(2),
                                          '0, 3'd0, held, csl_pkg::CH_EQ);
                            mode   = csl_pkg::MODE_IDLE;
                            held   = '0;
                            paired = 1'b1;
                        end
                        else
                            close_token();
                    end
                    if (!paired)
                    begin
                        if (mode == csl_pkg::MODE_NUM && char_digit(c))
                        begin
                            d = csl_pkg::VAL_W'(c - csl_pkg::CH_0);
                            if (acc > (VAL_TOP - d) / 10)
                                acc = VAL_TOP;
                            else
                                acc = acc * 10 + d;
                            if (run != csl_pkg::POS_MAX)
                                run = run + 1'b1;
                        end
                        else if (mode == csl_pkg::MODE_IDENT &&
                                 (char_letter(c) || char_digit(c)))
                            ident_char(c);
                        else
                        begin
                            close_token();
                            if (char_digit(c))
                            begin
                                mode      = csl_pkg::MODE_NUM;
                                tok_begin = here;
                                run       = csl_pkg::POS_W'(1);
                                acc       = csl_pkg::VAL_W'(c - csl_pkg::CH_0);
                            end
                            else if (char_letter(c))
                            begin
                                mode      = csl_pkg::MODE_IDENT;
                                tok_begin = here;
                                run       = '0;
                                kw_live   = csl_pkg::KW_ALL;
                                ident_char(c);
                            end
                            else if (c == csl_pkg::CH_EQ || c == csl_pkg::CH_BANG ||
                                     c == csl_pkg::CH_LT || c == csl_pkg::CH_GT)
                            begin
                                // may pair with a following '='
                                mode      = csl_pkg::MODE_PUNCT;
                                tok_begin = here;
                                held      = c;
                            end
                            else if (char_mark(c))
                                predict_token(csl_pkg::KIND_PUNCT, here, csl_pkg::POS_W'(1),
                                              '0, 3'd0, c, 8'd0);
                            else if (!char_blank(c))
                            begin
                                predict_token(csl_pkg::KIND_ERR, here, csl_pkg::POS_W'(1),
                                              '0, 3'd0, 8'd0, 8'd0);
                                mode = csl_pkg::MODE_DROP;
                            end
                        end
                    end
                end
                offset = here + 1'b1;
            end
            if (eot)
            begin
                if (mode != csl_pkg::MODE_DROP)
                    close_token();
                predict_token(csl_pkg::KIND_END, offset, '0, '0, 3'd0, 8'd0, 8'd0);
                clear();
            end
            if (tokens_due.size() > first_new)
            begin
                t      = tokens_due.pop_back();
                t.last = 1'b1;
                tokens_due.push_back(t);
            end
        endfunction

        function void compare_field(string name, logic [csl_pkg::VAL_W-1:0] want,
                                    logic [csl_pkg::VAL_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_token(lex_token_t seen);
            lex_token_t want;
            if (tokens_due.size() == 0)
            begin
                $error("token with nothing pending: kind %0d start %0d", seen.kind, seen.start);
                mismatches++;
                return;
            end
            want = tokens_due.pop_front();
            matched++;
            kind_seen[seen.kind]++;
            if (seen.kind == csl_pkg::KIND_NUM && seen.value == VAL_TOP)
                saturated++;
            compare_field("token_kind", csl_pkg::VAL_W'(want.kind),
                          csl_pkg::VAL_W'(seen.kind));
            compare_field("token_start", csl_pkg::VAL_W'(want.start),
                          csl_pkg::VAL_W'(seen.start));
            compare_field("token_length", csl_pkg::VAL_W'(want.length),
                          csl_pkg::VAL_W'(seen.length));
            compare_field("number_value", want.value, seen.value);
            compare_field("keyword_index", csl_pkg::VAL_W'(want.kw),
                          csl_pkg::VAL_W'(seen.kw));
            compare_field("punct_first", csl_pkg::VAL_W'(want.p1),
                          csl_pkg::VAL_W'(seen.p1));
            compare_field("punct_second", csl_pkg::VAL_W'(want.p2),
                          csl_pkg::VAL_W'(seen.p2));
            compare_field("last_of_run", csl_pkg::VAL_W'(want.last),
                          csl_pkg::VAL_W'(seen.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    csl_in_if  text_ch();
    csl_out_if tok_ch();

    c_subset_lexer_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (tok_ch)
    );

    lex_tracker tracker = new();

    logic [7:0] src_text[$];
    bit         steady;
    bit         hold_request;
    int         burst_left;
    int         items_sent;
    int         text_no;
    int         stuck;
    int         rx_cycle;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- text side ----------------

    task automatic send_item(input logic [7:0] c, input bit has, input bit eot);
        int gap;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                repeat (gap)
                begin
                    @(negedge clk);
                    text_ch.valid = 1'b0;
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        text_ch.valid       = 1'b1;
        text_ch.text_byte   = c;
        text_ch.has_byte    = has;
        text_ch.end_of_text = eot;
        do @(posedge clk); while (!text_ch.ready);
        tracker.take_byte(c, has, eot);
        if (has || eot)
            items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        text_ch.valid = 1'b0;
        burst_left    = 0;
        while (tracker.tokens_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // sends the buffered text; sprinkles empty items in between
    task automatic play_text(input bit bare_end);
        int last;
        last = src_text.size() - 1;
        for (int i = 0; i <= last; i++)
        begin
            if ($urandom_range(0, 32) == 0)
                send_item(8'($urandom()), 1'b0, 1'b0);
            send_item(src_text[i], 1'b1, !bare_end && i == last);
        end
        if (bare_end)
            send_item(8'($urandom()), 1'b0, 1'b1);
        src_text.delete();
    endtask

    function automatic void append_word(string s);
        for (int i = 0; i < s.len(); i++)
            src_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return csl_pkg::CH_LA + 8'(r);
        if (r < 52)
            return csl_pkg::CH_A + 8'(r - 26);
        return csl_pkg::CH_USCR;
    endfunction

    function automatic logic [7:0] rand_digit();
        return csl_pkg::CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_mark();
        logic [7:0] c;
        do c = 8'($urandom_range(csl_pkg::CH_BANG, csl_pkg::CH_TILDE));
        while (!lex_tracker::char_mark(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_lead();
        unique case ($urandom_range(0, 3))
            0:       return csl_pkg::CH_EQ;
            1:       return csl_pkg::CH_BANG;
            2:       return csl_pkg::CH_LT;
            default: return csl_pkg::CH_GT;
        endcase
    endfunction

    function automatic logic [7:0] rand_bad();
        unique case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'($urandom_range(1, 8));
            2:       return 8'($urandom_range(14, 31));
            3:       return 8'h7F;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic void append_token();
        int    pick;
        int    n;
        string w;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            append_word(lex_tracker::kw_word(kw_t'($urandom_range(0, csl_pkg::NUM_KW - 1))));
        else if (pick < 32)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // keyword prefix, possibly extended: near misses
                w = lex_tracker::kw_word(kw_t'($urandom_range(0, csl_pkg::NUM_KW - 1)));
                n = $urandom_range(1, w.len());
                for (int i = 0; i < n; i++)
                    src_text.push_back(w[i]);
                if ($urandom_range(0, 1) == 1)
                    src_text.push_back($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
            end
            else
            begin
                src_text.push_back(rand_letter());
                repeat ($urandom_range(0, 7))
                    src_text.push_back($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
            end
        end
        else if (pick < 50)
        begin
            // long runs of digits can reach saturation
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
            repeat (n) src_text.push_back(rand_digit());
        end
        else if (pick < 64)
        begin
            src_text.push_back(rand_lead());
            src_text.push_back(csl_pkg::CH_EQ);
        end
        else if (pick < 74)
            src_text.push_back(rand_lead());
        else if (pick < 94)
            src_text.push_back(rand_mark());
        else
            src_text.push_back(rand_bad());
        if ($urandom_range(0, 9) < 6)
            repeat ($urandom_range(1, 2))
                src_text.push_back($urandom_range(0, 5) == 5 ?
                                   csl_pkg::CH_SPACE :
                                   csl_pkg::CH_TAB + 8'($urandom_range(0, 4)));
    endfunction

    task automatic random_text(input int ntok, input bit garbage);
        if (garbage)
            repeat ($urandom_range(1, 8)) src_text.push_back(8'($urandom()));
        else
            repeat (ntok) append_token();
        steady = ($urandom_range(0, 3) == 0);
        play_text($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = '0;
        text_ch.has_byte    = 1'b0;
        text_ch.end_of_text = 1'b0;
        steady              = 1'b0;
        burst_left          = 0;
        items_sent          = 0;
        text_no             = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // keyword, >= and != pairs, underscore ident, error then dropped tail
        append_word("if>=7\t_a!=b");
        src_text.push_back(8'h00);
        append_word("z");
        play_text(1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);    // empty text
        send_item(8'hFF, 1'b1, 1'b1);    // error and end from one item
        append_word("<x~");              // lone lead, then three tokens on the last
        play_text(1'b0);
        append_word("a=");               // end closes a pending lead
        play_text(1'b0);

        while (items_sent < ITEM_TARGET)
        begin
            if (text_no == 3)
                hold_request = 1'b1;
            if (text_no == 9)
                wait_drained();
            random_text(text_no == 3 ? 12 : $urandom_range(1, 10),
                        text_no != 3 && $urandom_range(0, 9) == 0);
            text_no++;
        end

        wait_drained();
        $display("Sent %0d text items in %0d random texts plus prologue; %0d tokens checked",
                 items_sent, text_no, tracker.matched);
        $display("punct %0d, ident %0d, keyword %0d, number %0d (%0d saturated), end %0d, error %0d",
                 tracker.kind_seen[csl_pkg::KIND_PUNCT], tracker.kind_seen[csl_pkg::KIND_IDENT],
                 tracker.kind_seen[csl_pkg::KIND_KW], tracker.kind_seen[csl_pkg::KIND_NUM],
                 tracker.saturated, tracker.kind_seen[csl_pkg::KIND_END],
                 tracker.kind_seen[csl_pkg::KIND_ERR]);
        if (tracker.tokens_due.size() != 0)
            $error("%0d tokens never arrived", tracker.tokens_due.size());
        if (tracker.mismatches == 0 && tracker.tokens_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ---------------- token side ----------------

    initial
    begin
        stall_t style;
        tok_ch.ready = 1'b0;
        hold_request = 1'b0;
        rx_cycle     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // long hold so the bundle queue fills and text.ready drops
                hold_request = 1'b0;
                tok_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                rx_cycle++;
                style = stall_t'((rx_cycle / 128) % 4);
                unique case (style)
                    RX_OPEN:     tok_ch.ready = 1'b1;
                    RX_COIN:     tok_ch.ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: tok_ch.ready = (rx_cycle % 7) >= 3;
                    default:     tok_ch.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        lex_token_t seen;
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            seen.kind   = tok_ch.token_kind;
            seen.start  = tok_ch.token_start;
            seen.length = tok_ch.token_length;
            seen.value  = tok_ch.number_value;
            seen.kw     = tok_ch.keyword_index;
            seen.p1     = tok_ch.punct_first;
            seen.p2     = tok_ch.punct_second;
            seen.last   = tok_ch.last_of_run;
            tracker.match_token(seen);
        end
    end

    // watchdog: cycles in a row with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready))
            stuck <= 0;
        else if (stuck >= STUCK_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stuck <= stuck + 1;
    end

endmodule

`default_nettype wire
